>>> sv/krg_pkg.sv
// Shared types and constants for the key repeat generator.
`default_nettype none

package krg_pkg;

	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_TEXT    = 2'd1,
		CMD_PRESS   = 2'd2,
		CMD_RELEASE = 2'd3
	} krg_cmd_t;

	typedef enum logic {
		KIND_TEXT = 1'b0,
		KIND_KEY  = 1'b1
	} krg_kind_t;

	localparam logic REG_INITIAL_DELAY   = 1'b0;
	localparam logic REG_REPEAT_INTERVAL = 1'b1;

	localparam logic [15:0] INITIAL_DELAY_RST   = 16'd500;
	localparam logic [15:0] REPEAT_INTERVAL_RST = 16'd50;
	localparam logic [16:0] REPEAT_MAX          = 17'h1FFFF;

	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		krg_cmd_t    command;
		logic [15:0] elapsed_time;
		logic [7:0]  key_code;
		logic [20:0] text_char;
		logic        alt_held;
		logic        control_held;
		logic        shift_held;
	} krg_in_t;

	typedef struct packed {
		logic        event_kind;
		logic [7:0]  out_key_code;
		logic [20:0] out_text_char;
		logic        out_alt;
		logic        out_control;
		logic        out_shift;
		logic        last_of_run;
	} krg_out_t;

	typedef struct packed {
		logic [7:0]  key_code;
		logic [20:0] text_char;
		logic        alt;
		logic        ctl;
		logic        sft;
	} krg_latch_t;

	// Push request into the result queue; push1 is only set together with push0.
	typedef struct packed {
		logic push0;
		logic push1;
	} krg_push_t;

endpackage

`default_nettype wire

>>> sv/krg_queue.sv
// Result queue: takes up to two beats per cycle, hands out one beat per cycle while out_ready is high.
`default_nettype none

module krg_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire krg_pkg::krg_push_t push,
	input  wire krg_pkg::krg_out_t  entry0,
	input  wire krg_pkg::krg_out_t  entry1,
	output logic                   room2,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output krg_pkg::krg_out_t      out_data
);

	krg_pkg::krg_out_t mem_q [krg_pkg::QUEUE_DEPTH];
	logic [krg_pkg::PTR_W-1:0] wr_ptr_q;
	logic [krg_pkg::PTR_W-1:0] rd_ptr_q;
	logic [krg_pkg::CNT_W-1:0] count_q;
	logic                      pop;
	logic [krg_pkg::CNT_W-1:0] push_n;

	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign room2     = (count_q <= krg_pkg::CNT_W'(krg_pkg::QUEUE_DEPTH - 2));
	assign push_n    = krg_pkg::CNT_W'(push.push0) + krg_pkg::CNT_W'(push.push1);

	always_ff @(posedge clk) begin
		if (push.push0) begin
			mem_q[wr_ptr_q] <= entry0;
		end
		if (push.push1) begin
			mem_q[wr_ptr_q + krg_pkg::PTR_W'(1)] <= entry1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + krg_pkg::PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + krg_pkg::PTR_W'(1);
			end
			count_q <= count_q + push_n - krg_pkg::CNT_W'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= krg_pkg::CNT_W'(krg_pkg::QUEUE_DEPTH))
		else $error("result queue count past its depth");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.push0 |-> count_q <= krg_pkg::CNT_W'(krg_pkg::QUEUE_DEPTH - 2))
		else $error("push into result queue without room for two beats");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.push1 |-> push.push0)
		else $error("second push slot used without the first");

endmodule

`default_nettype wire

>>> sv/key_repeat_generator_unit.sv
// Top level of the typematic key repeat generator.
// A tick's repeat beats enter the result queue as the tick beat is taken.
// Throughput: one input beat per cycle while the result queue has room for two beats;
// a tick repeating text and key sends one beat per cycle while out_ready is high.
// Reset (arst_n, asynchronous, active low) clears timers, held flags, latched events
// and the queue, and loads the delay and interval registers with 500 and 50.
`default_nettype none

module key_repeat_generator_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire krg_pkg::krg_in_t   in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output krg_pkg::krg_out_t       out_data,
	input  wire logic              cfg_wen,
	input  wire logic              cfg_index,
	input  wire logic [15:0]       cfg_data
);

	// Configuration registers.
	logic [15:0] initial_delay_q;
	logic [15:0] repeat_interval_q;

	// Typematic state.
	logic [15:0]         delay_timer_q;
	logic [16:0]         repeat_timer_q;
	logic                text_held_q;
	logic                key_held_q;
	krg_pkg::krg_latch_t text_latch_q;
	krg_pkg::krg_latch_t key_latch_q;

	logic                in_fire;
	logic                room2;
	logic [16:0]         delay_sum;
	logic [15:0]         delay_next;
	logic [15:0]         repeat_add;
	logic [17:0]         repeat_sum;
	logic [16:0]         repeat_next;
	logic                repeat_due;
	krg_pkg::krg_latch_t in_latch;
	krg_pkg::krg_push_t  push;
	krg_pkg::krg_out_t   entry0;
	krg_pkg::krg_out_t   entry1;
	krg_pkg::krg_out_t   text_beat;
	krg_pkg::krg_out_t   key_beat;

	// The queue always keeps room for the two beats one tick can produce, so the
	// input side never has to look at what kind of item is waiting.
	assign in_ready = room2;
	assign in_fire  = in_valid && in_ready;

	assign in_latch = '{
		key_code:  in_data.key_code,
		text_char: in_data.text_char,
		alt:       in_data.alt_held,
		ctl:       in_data.control_held,
		sft:       in_data.shift_held
	};

	// Tick arithmetic. While the delay is still running, only the part of the
	// elapsed time that reaches the delay goes to the repeat timer; once the delay
	// has passed (or was lowered below the timer) the whole elapsed time goes there.
	always_comb begin
		delay_sum  = {1'b0, delay_timer_q} + {1'b0, in_data.elapsed_time};
		delay_next = delay_timer_q;
		repeat_add = '0;
		if (delay_timer_q < initial_delay_q) begin
			if (delay_sum >= {1'b0, initial_delay_q}) begin
				repeat_add = initial_delay_q - delay_timer_q;
				delay_next = initial_delay_q;
			end else begin
				delay_next = delay_sum[15:0];
			end
		end else begin
			repeat_add = in_data.elapsed_time;
		end
		repeat_sum  = {1'b0, repeat_timer_q} + {2'b00, repeat_add};
		// The sum stays below twice the ceiling, so its top bit flags overflow.
		repeat_next = repeat_sum[17] ? krg_pkg::REPEAT_MAX : repeat_sum[16:0];
		repeat_due  = (delay_next >= initial_delay_q) &&
			(repeat_next >= {1'b0, repeat_interval_q});
	end

	// Repeat beats: text first, then key; the last one present closes the run.
	always_comb begin
		text_beat = '{
			event_kind:    krg_pkg::KIND_TEXT,
			out_key_code:  text_latch_q.key_code,
			out_text_char: text_latch_q.text_char,
			out_alt:       text_latch_q.alt,
			out_control:   text_latch_q.ctl,
			out_shift:     text_latch_q.sft,
			last_of_run:   !key_held_q
		};
		key_beat = '{
			event_kind:    krg_pkg::KIND_KEY,
			out_key_code:  key_latch_q.key_code,
			out_text_char: key_latch_q.text_char,
			out_alt:       key_latch_q.alt,
			out_control:   key_latch_q.ctl,
			out_shift:     key_latch_q.sft,
			last_of_run:   1'b1
		};
		entry0 = text_held_q ? text_beat : key_beat;
		entry1 = key_beat;
		push   = '{push0: 1'b0, push1: 1'b0};
		if (in_fire && (in_data.command == krg_pkg::CMD_TICK) && repeat_due) begin
			push.push0 = text_held_q || key_held_q;
			push.push1 = text_held_q && key_held_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_delay_q   <= krg_pkg::INITIAL_DELAY_RST;
			repeat_interval_q <= krg_pkg::REPEAT_INTERVAL_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				krg_pkg::REG_INITIAL_DELAY:   initial_delay_q   <= cfg_data;
				krg_pkg::REG_REPEAT_INTERVAL: repeat_interval_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_timer_q  <= '0;
			repeat_timer_q <= '0;
			text_held_q    <= 1'b0;
			key_held_q     <= 1'b0;
			text_latch_q   <= '0;
			key_latch_q    <= '0;
		end else if (in_fire) begin
			unique case (in_data.command)
				krg_pkg::CMD_TICK: begin
					delay_timer_q  <= delay_next;
					repeat_timer_q <= repeat_due ? '0 : repeat_next;
				end
				krg_pkg::CMD_TEXT: begin
					text_latch_q <= in_latch;
					text_held_q  <= 1'b1;
				end
				krg_pkg::CMD_PRESS: begin
					// A press while a key is already held is dropped whole.
					if (!key_held_q) begin
						key_latch_q   <= in_latch;
						key_held_q    <= 1'b1;
						delay_timer_q <= '0;
					end
				end
				krg_pkg::CMD_RELEASE: begin
					text_held_q <= 1'b0;
					key_held_q  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	krg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.entry0    (entry0),
		.entry1    (entry1),
		.room2     (room2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_push_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		push.push0 |-> in_fire && (in_data.command == krg_pkg::CMD_TICK))
		else $error("repeat beat produced by something other than a tick");

	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (in_data.command == krg_pkg::CMD_RELEASE)
		|=> !text_held_q && !key_held_q)
		else $error("held flags survive a release");

	a_repeat_clears: assert property (@(posedge clk) disable iff (!arst_n)
		push.push0 |=> repeat_timer_q == '0)
		else $error("repeat timer not cleared after a repeat");

endmodule

`default_nettype wire

>>> test/key_repeat_generator_tb.sv
// Self-checking testbench for the typematic key repeat generator unit.
`timescale 1ns / 100ps

module testbench;

	localparam int MAX_WAIT      = 17;
	localparam int PHASES        = 7;
	localparam int PHASE_ITEMS   = 250;
	localparam int PRESSURE_HOLD = 600;
	localparam int PRESSURE_AT   = 40;
	localparam int SETTLE_CYCLES = 4;
	localparam int PICK_RANDOM   = -1;
	localparam int DIRECTED_ROWS = 19;
	localparam int REPORT_LIMIT  = 10;
	localparam krg_pkg::krg_out_t NO_REPEAT = '0;

	// One row of the directed table. When typed is set, the repeat beats in rep0/rep1
	// (typed_n of them) are the expected results; otherwise the predictor decides.
	typedef struct packed {
		krg_pkg::krg_in_t  beat;
		logic              typed;
		logic [1:0]        typed_n;
		krg_pkg::krg_out_t rep0;
		krg_pkg::krg_out_t rep1;
	} dir_row_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	krg_pkg::krg_in_t  in_data;
	logic              out_valid;
	logic              out_ready;
	krg_pkg::krg_out_t out_data;
	logic              cfg_wen;
	logic              cfg_index;
	logic [15:0]       cfg_data;

	key_repeat_generator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// The predictor keeps its own copy of the settings, the two timers, the held
	// flags and the two latched events.
	logic [15:0]         delay_limit;
	logic [15:0]         repeat_limit;
	logic [15:0]         delay_count;
	logic [16:0]         repeat_count;
	logic                text_down;
	logic                key_down;
	krg_pkg::krg_latch_t text_latch;
	krg_pkg::krg_latch_t key_latch;

	// Repeat beats that the block still owes us, oldest first.
	krg_pkg::krg_out_t pending_repeats[$];

	int mismatches;
	int items_done;
	int send_quiet;
	int phase_delay [PHASES];
	int phase_interval [PHASES];
	dir_row_t directed_rows [DIRECTED_ROWS];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs; the normal run ends far earlier.
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic krg_pkg::krg_in_t mk_beat(input krg_pkg::krg_cmd_t cmd,
			input logic [15:0] el, input logic [7:0] key, input logic [20:0] ch,
			input logic a, input logic c, input logic s);
		mk_beat = {cmd, el, key, ch, a, c, s};
	endfunction

	function automatic krg_pkg::krg_out_t mk_repeat(input krg_pkg::krg_kind_t kind,
			input logic [7:0] key, input logic [20:0] ch, input logic a, input logic c,
			input logic s, input logic last);
		mk_repeat = {kind, key, ch, a, c, s, last};
	endfunction

	// Advances the predicted state by one accepted beat and returns how many repeat
	// beats it causes (0 to 2), in r0 and r1 in the order the block must send them.
	function automatic int predict_repeats(input krg_pkg::krg_in_t beat,
			output krg_pkg::krg_out_t r0, output krg_pkg::krg_out_t r1);
		logic [16:0] delay_sum;
		logic [17:0] repeat_sum;
		logic [15:0] gain;
		logic        gain_en;
		int          n;
		n = 0;
		r0 = NO_REPEAT;
		r1 = NO_REPEAT;
		gain = '0;
		gain_en = 1'b0;
		case (beat.command)
			krg_pkg::CMD_TEXT: begin
				text_latch = {beat.key_code, beat.text_char, beat.alt_held,
					beat.control_held, beat.shift_held};
				text_down = 1'b1;
			end
			krg_pkg::CMD_PRESS: begin
				// A second press while a key is down leaves everything alone.
				if (!key_down) begin
					delay_count = '0;
					key_latch = {beat.key_code, beat.text_char, beat.alt_held,
						beat.control_held, beat.shift_held};
					key_down = 1'b1;
				end
			end
			krg_pkg::CMD_RELEASE: begin
				text_down = 1'b0;
				key_down = 1'b0;
			end
			default: begin
				if (delay_count < delay_limit) begin
					delay_sum = {1'b0, delay_count} + {1'b0, beat.elapsed_time};
					if (delay_sum >= {1'b0, delay_limit}) begin
						// Only the part needed to reach the delay spills into the
						// repeat timer on the crossing tick.
						gain = delay_limit - delay_count;
						gain_en = 1'b1;
						delay_count = delay_limit;
					end else begin
						delay_count = delay_sum[15:0];
					end
				end else begin
					gain = beat.elapsed_time;
					gain_en = 1'b1;
				end
				if (gain_en) begin
					repeat_sum = {1'b0, repeat_count} + {2'b00, gain};
					repeat_count = (repeat_sum > {1'b0, krg_pkg::REPEAT_MAX}) ?
						krg_pkg::REPEAT_MAX : repeat_sum[16:0];
				end
				if (delay_count >= delay_limit && repeat_count >= {1'b0, repeat_limit}) begin
					if (text_down) begin
						r0 = mk_repeat(krg_pkg::KIND_TEXT, text_latch.key_code,
							text_latch.text_char, text_latch.alt, text_latch.ctl,
							text_latch.sft, 1'b0);
						n = 1;
					end
					if (key_down) begin
						if (n == 0) begin
							r0 = mk_repeat(krg_pkg::KIND_KEY, key_latch.key_code,
								key_latch.text_char, key_latch.alt, key_latch.ctl,
								key_latch.sft, 1'b0);
						end else begin
							r1 = mk_repeat(krg_pkg::KIND_KEY, key_latch.key_code,
								key_latch.text_char, key_latch.alt, key_latch.ctl,
								key_latch.sft, 1'b0);
						end
						n++;
					end
					if (n == 1) begin
						r0.last_of_run = 1'b1;
					end else if (n == 2) begin
						r1.last_of_run = 1'b1;
					end
					// The timer clears even when nothing is held.
					repeat_count = '0;
				end
			end
		endcase
		return n;
	endfunction

	// Random beat with the given command. All fields are random so every bit moves;
	// the elapsed time is scaled to the current settings so repeats actually happen.
	function automatic krg_pkg::krg_in_t random_beat(input krg_pkg::krg_cmd_t cmd);
		int          scale;
		logic [15:0] span;
		scale = int'(repeat_limit);
		if (int'(delay_limit) / 4 > scale) begin
			scale = int'(delay_limit) / 4;
		end
		if (scale < 16) begin
			scale = 16;
		end
		case ($urandom_range(0, 15))
			0: begin
				span = 16'h0000;
			end
			1: begin
				span = 16'hFFFF;
			end
			2, 3: begin
				span = 16'($urandom);
			end
			default: begin
				span = 16'($urandom_range(0, scale));
			end
		endcase
		random_beat = mk_beat(cmd, span, 8'($urandom_range(0, 255)),
			21'($urandom_range(0, 21'h10FFFF)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endfunction

	// Offers one input beat after a random gap and returns at the edge where it is
	// taken. Valid is left high, so a following beat with no gap goes out back to back.
	task automatic offer_beat(input krg_pkg::krg_in_t beat);
		int gap;
		if (send_quiet > 0) begin
			gap = 0;
			send_quiet--;
		end else begin
			gap = $urandom_range(0, MAX_WAIT);
			if ($urandom_range(0, 39) == 0) begin
				send_quiet = $urandom_range(10, 40);
			end
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drive_and_predict(input krg_pkg::krg_in_t beat);
		krg_pkg::krg_out_t r0;
		krg_pkg::krg_out_t r1;
		int                n;
		offer_beat(beat);
		// A press on top of a held key does nothing, so it does not count as work.
		if (!(beat.command == krg_pkg::CMD_PRESS && key_down)) begin
			items_done++;
		end
		n = predict_repeats(beat, r0, r1);
		if (n > 0) begin
			pending_repeats.push_back(r0);
		end
		if (n > 1) begin
			pending_repeats.push_back(r1);
		end
	endtask

	// Drops valid, waits until every expected repeat beat has come back, and then lets
	// a beat that causes no result finish inside the block.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_repeats.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result side: random stalls per beat, quiet stretches, and one long hold-off
	// that lets the result queue fill so the block has to stall its input.
	initial begin : result_sink
		krg_pkg::krg_out_t want;
		int                stall;
		int                quiet;
		int                seen;
		logic              held_off;
		out_ready = 1'b0;
		quiet = 0;
		seen = 0;
		held_off = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!held_off && seen == PRESSURE_AT) begin
				held_off = 1'b1;
				stall = PRESSURE_HOLD;
			end else if (quiet > 0) begin
				stall = 0;
				quiet--;
			end else begin
				stall = $urandom_range(0, MAX_WAIT);
				if ($urandom_range(0, 39) == 0) begin
					quiet = $urandom_range(10, 40);
				end
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			seen++;
			if (pending_repeats.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$write("%0t: repeat beat with nothing expected: kind=%0d key=%02h",
						$time, out_data.event_kind, out_data.out_key_code);
					$display(" char=%06h mods=%b%b%b last=%b", out_data.out_text_char,
						out_data.out_alt, out_data.out_control, out_data.out_shift,
						out_data.last_of_run);
				end
			end else begin
				want = pending_repeats.pop_front();
				if (out_data.event_kind != want.event_kind ||
						out_data.out_key_code != want.out_key_code ||
						out_data.out_text_char != want.out_text_char ||
						out_data.out_alt != want.out_alt ||
						out_data.out_control != want.out_control ||
						out_data.out_shift != want.out_shift ||
						out_data.last_of_run != want.last_of_run) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$write("%0t: repeat beat mismatch: expected kind=%0d key=%02h",
							$time, want.event_kind, want.out_key_code);
						$display(" char=%06h mods=%b%b%b last=%b", want.out_text_char,
							want.out_alt, want.out_control, want.out_shift,
							want.last_of_run);
						$write("%0t:                       actual   kind=%0d key=%02h",
							$time, out_data.event_kind, out_data.out_key_code);
						$display(" char=%06h mods=%b%b%b last=%b", out_data.out_text_char,
							out_data.out_alt, out_data.out_control, out_data.out_shift,
							out_data.last_of_run);
					end
				end
			end
		end
	end

	// Stimulus side: reset, the directed table at reset settings, then one random
	// phase per setting pair.
	initial begin : stimulus
		krg_pkg::krg_out_t r0;
		krg_pkg::krg_out_t r1;
		int                n;
		int                ticks;
		logic [15:0]       new_delay;
		logic [15:0]       new_interval;
		krg_pkg::krg_cmd_t extra_cmd;

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_wen = 1'b0;
		cfg_index = krg_pkg::REG_INITIAL_DELAY;
		cfg_data = '0;
		mismatches = 0;
		items_done = 0;
		send_quiet = 0;
		delay_limit = krg_pkg::INITIAL_DELAY_RST;
		repeat_limit = krg_pkg::REPEAT_INTERVAL_RST;
		delay_count = '0;
		repeat_count = '0;
		text_down = 1'b0;
		key_down = 1'b0;
		text_latch = '0;
		key_latch = '0;

		// Settings walked by the random phases: zero delay and interval, both at the
		// top, mixed extremes, a drop from the longest delay to a short one (the
		// delay timer then sits above the new delay), a random pair, and small ones.
		phase_delay    = '{0, 65535, 0, 65535, 100, PICK_RANDOM, 20};
		phase_interval = '{0, 65535, 65535, 0, 10, PICK_RANDOM, 5};

		// Directed table, run at the reset settings (delay 500, interval 50).
		// A tick right after reset does nothing.
		directed_rows[0] = {mk_beat(krg_pkg::CMD_TICK, 16'h0000, 8'h00, 21'h000000, 1'b0,
			1'b0, 1'b0), 1'b1, 2'd0, NO_REPEAT, NO_REPEAT};
		// Text event with every latched field at its top value.
		directed_rows[1] = {mk_beat(krg_pkg::CMD_TEXT, 16'h0000, 8'hFF, 21'h10FFFF, 1'b1,
			1'b1, 1'b1), 1'b1, 2'd0, NO_REPEAT, NO_REPEAT};
		directed_rows[2] = {mk_beat(krg_pkg::CMD_PRESS, 16'h1234, 8'hA5, 21'h000000, 1'b1,
			1'b0, 1'b1), 1'b1, 2'd0, NO_REPEAT, NO_REPEAT};
		// The longest tick crosses the delay at once; 500 spills over, past the
		// interval, so text then key come out.
		directed_rows[3] = {mk_beat(krg_pkg::CMD_TICK, 16'hFFFF, 8'h5A, 21'h0AAAAA, 1'b0,
			1'b1, 1'b0), 1'b1, 2'd2,
			mk_repeat(krg_pkg::KIND_TEXT, 8'hFF, 21'h10FFFF, 1'b1, 1'b1, 1'b1, 1'b0),
			mk_repeat(krg_pkg::KIND_KEY, 8'hA5, 21'h000000, 1'b1, 1'b0, 1'b1, 1'b1)};
		// A press while the key is down is ignored.
		directed_rows[4] = {mk_beat(krg_pkg::CMD_PRESS, 16'h0000, 8'h00, 21'h1FFFFF, 1'b0,
			1'b1, 1'b0), 1'b1, 2'd0, NO_REPEAT, NO_REPEAT};
		directed_rows[5] = {mk_beat(krg_pkg::CMD_TICK, 16'd49, 8'h00, 21'h000000, 1'b0,
			1'b0, 1'b0), 1'b0, 2'd0, NO_REPEAT, NO_REPEAT};
		directed_rows[6] = {mk_beat(krg_pkg::CMD_TICK, 16'd1, 8'h00, 21'h000000, 1'b0,
			1'b0, 1'b0), 1'b0, 2'd0, NO_REPEAT, NO_REPEAT};
		directed_rows[7] = {mk_beat(krg_pkg::CMD_RELEASE, 16'h0000, 8'h00, 21'h000000, 1'b0,
			1'b0, 1'b0), 1'b1, 2'd0, NO_REPEAT, NO_REPEAT};
		// Timers run on after the release, but nothing is held at the interval.
		directed_rows[8] = {mk_beat(krg_pkg::CMD_TICK, 16'hFFFF, 8'hFF, 21'h10FFFF, 1'b1,
			1'b1, 1'b1), 1'b1, 2'd0, NO_REPEAT, NO_REPEAT};
		// Text only, all fields at zero.
		directed_rows[9] = {mk_beat(krg_pkg::CMD_TEXT, 16'h0000, 8'h00, 21'h000000, 1'b0,
			1'b0, 1'b0), 1'b0, 2'd0, NO_REPEAT, NO_REPEAT};
		directed_rows[10] = {mk_beat(krg_pkg::CMD_TICK, 16'd50, 8'h00, 21'h000000, 1'b0,
			1'b0, 1'b0), 1'b0, 2'd0, NO_REPEAT, NO_REPEAT};
		// A fresh press restarts the delay; the crossing tick spills only one unit.
		directed_rows[11] = {mk_beat(krg_pkg::CMD_PRESS, 16'h0000, 8'h3C, 21'h012345, 1'b0,
			1'b1, 1'b0), 1'b0, 2'd0, NO_REPEAT, NO_REPEAT};
		directed_rows[12] = {mk_beat(krg_pkg::CMD_TICK, 16'd499, 8'h00, 21'h000000, 1'b0,
			1'b0, 1'b0), 1'b0, 2'd0, NO_REPEAT, NO_REPEAT};
		directed_rows[13] = {mk_beat(krg_pkg::CMD_TICK, 16'd2, 8'h00, 21'h000000, 1'b0,
			1'b0, 1'b0), 1'b0, 2'd0, NO_REPEAT, NO_REPEAT};
		directed_rows[14] = {mk_beat(krg_pkg::CMD_TICK, 16'd49, 8'h00, 21'h000000, 1'b0,
			1'b0, 1'b0), 1'b0, 2'd0, NO_REPEAT, NO_REPEAT};
		// New text while the key stays down replaces only the text latch.
		directed_rows[15] = {mk_beat(krg_pkg::CMD_TEXT, 16'h0000, 8'h81, 21'h0F0F0F, 1'b1,
			1'b0, 1'b0), 1'b0, 2'd0, NO_REPEAT, NO_REPEAT};
		directed_rows[16] = {mk_beat(krg_pkg::CMD_TICK, 16'd50, 8'h00, 21'h000000, 1'b0,
			1'b0, 1'b0), 1'b0, 2'd0, NO_REPEAT, NO_REPEAT};
		directed_rows[17] = {mk_beat(krg_pkg::CMD_RELEASE, 16'hFFFF, 8'hFF, 21'h10FFFF, 1'b1,
			1'b1, 1'b1), 1'b0, 2'd0, NO_REPEAT, NO_REPEAT};
		directed_rows[18] = {mk_beat(krg_pkg::CMD_TICK, 16'h0000, 8'h00, 21'h000000, 1'b0,
			1'b0, 1'b0), 1'b0, 2'd0, NO_REPEAT, NO_REPEAT};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Typed rows still run through the predictor so its state follows the block,
		// but only the typed beats are expected.
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			offer_beat(directed_rows[i].beat);
			n = predict_repeats(directed_rows[i].beat, r0, r1);
			if (directed_rows[i].typed) begin
				n = int'(directed_rows[i].typed_n);
				r0 = directed_rows[i].rep0;
				r1 = directed_rows[i].rep1;
			end
			if (n > 0) begin
				pending_repeats.push_back(r0);
			end
			if (n > 1) begin
				pending_repeats.push_back(r1);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			// Settings change only while the block has nothing in flight.
			wait_idle();
			new_delay = (phase_delay[p] == PICK_RANDOM) ? 16'($urandom_range(0, 65535)) :
				16'(phase_delay[p]);
			new_interval = (phase_interval[p] == PICK_RANDOM) ?
				16'($urandom_range(0, 65535)) : 16'(phase_interval[p]);
			cfg_wen <= 1'b1;
			cfg_index <= krg_pkg::REG_INITIAL_DELAY;
			cfg_data <= new_delay;
			@(posedge clk);
			cfg_index <= krg_pkg::REG_REPEAT_INTERVAL;
			cfg_data <= new_interval;
			@(posedge clk);
			cfg_wen <= 1'b0;
			delay_limit = new_delay;
			repeat_limit = new_interval;

			// Mostly well-formed key sessions: optional text, a press, a run of ticks
			// with the odd extra text or press mixed in, usually a release. One in ten
			// is a lone beat with a random command.
			items_done = 0;
			while (items_done < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0) begin
					drive_and_predict(random_beat(
						krg_pkg::krg_cmd_t'($urandom_range(0, 3))));
				end else begin
					if ($urandom_range(0, 3) != 0) begin
						drive_and_predict(random_beat(krg_pkg::CMD_TEXT));
					end
					if ($urandom_range(0, 9) != 0) begin
						drive_and_predict(random_beat(krg_pkg::CMD_PRESS));
					end
					ticks = $urandom_range(1, 12);
					for (int t = 0; t < ticks; t++) begin
						if ($urandom_range(0, 15) == 0) begin
							extra_cmd = ($urandom_range(0, 1) == 0) ? krg_pkg::CMD_TEXT :
								krg_pkg::CMD_PRESS;
							drive_and_predict(random_beat(extra_cmd));
						end
						drive_and_predict(random_beat(krg_pkg::CMD_TICK));
					end
					if ($urandom_range(0, 6) != 0) begin
						drive_and_predict(random_beat(krg_pkg::CMD_RELEASE));
					end
				end
			end
		end

		wait_idle();
		if (mismatches == 0 && pending_repeats.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

>>> sim.f
sv/krg_pkg.sv
sv/krg_queue.sv
sv/key_repeat_generator_unit.sv
test/key_repeat_generator_tb.sv
